FILE: design/eida_pkg.sv
package eida_pkg;

    // Fixed field widths of the request and result items.
    localparam int ACTION_W = 2;
    localparam int ENT_W    = 8;
    localparam int PAR_W    = 9;
    localparam int RID_W    = 9;
    localparam int STATUS_W = 2;

    // Request operations.
    localparam logic [ACTION_W-1:0] ACT_SPAWN   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DESPAWN = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SET_PAR = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_GET_PAR = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_DEAD = 2'd2;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

FILE: design/entity_id_allocator.sv
// Entity ID allocator.
// A request item is taken at a rising edge with start high and busy low. It carries
// action (spawn, despawn, set parent, get parent), entity_id and parent_id.
// Every request gives exactly one result item: result_id and status are valid for
// one cycle while done is high. The receiver cannot stall, so results are never held.
// The edge that accepts a request latches its fields and reads both memories. The
// request is resolved in ST_EXEC and written back at the edge that leaves that state,
// which also registers done, result_id and status. Busy is high for one cycle after
// each accepted request, so a new request is not taken before the last is written
// back; the read-modify-write through the synchronous-read memories sets this.
// State lives in two synchronous memories: the free-ID stack and a table that holds
// the alive bit and parent link of each ID, plus a free counter in flip-flops.
// After reset a clearing pass loads the stack with entry i = i and marks every ID
// dead with no parent. Busy stays high during that pass.
// After reset the first spawn returns the highest ID.
module entity_id_allocator #(
    parameter int ENTITY_COUNT = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [eida_pkg::ACTION_W-1:0] action,
    input  logic [eida_pkg::ENT_W-1:0]    entity_id,
    input  logic [eida_pkg::PAR_W-1:0]    parent_id,
    output logic                          done,
    output logic [eida_pkg::RID_W-1:0]    result_id,
    output logic [eida_pkg::STATUS_W-1:0] status
);
    import eida_pkg::*;

    localparam int IW   = (ENTITY_COUNT > 1) ? $clog2(ENTITY_COUNT) : 1;
    localparam int CW   = $clog2(ENTITY_COUNT + 1);
    localparam int XW   = (IW > ENT_W) ? IW : ENT_W;
    localparam int RW   = (IW > RID_W) ? IW : RID_W;
    localparam int MW   = PAR_W + 1;
    localparam logic [16:0]   EC_WIDE = 17'(ENTITY_COUNT);
    localparam logic [RID_W-1:0] NO_ID = EC_WIDE[RID_W-1:0];
    localparam logic [IW-1:0] LAST_ID = IW'(ENTITY_COUNT - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(ENTITY_COUNT);

    // Memories: free-ID stack and the {alive, parent} table.
    logic [IW-1:0] stack_mem [ENTITY_COUNT];
    logic [MW-1:0] meta_mem  [ENTITY_COUNT];

    state_t            state_reg, state_next;
    logic [IW-1:0]     clr_reg, clr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [ACTION_W-1:0] act_reg;
    logic [ENT_W-1:0]  ent_reg;
    logic [PAR_W-1:0]  par_reg;
    logic [IW-1:0]     stack_rd_reg;
    logic [MW-1:0]     meta_rd_reg;
    logic              done_reg, done_next;
    logic [RID_W-1:0]  rid_reg, rid_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic              accept;
    logic [XW-1:0]     in_ent_x, ent_x;
    logic [IW-1:0]     in_idx, ent_idx;
    logic              in_range;
    logic [IW-1:0]     stack_raddr;
    logic              stack_we, meta_we;
    logic [IW-1:0]     stack_waddr, meta_waddr;
    logic [IW-1:0]     stack_wdata;
    logic [MW-1:0]     meta_wdata;
    logic [RW-1:0]     pop_id_x;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    // Entity index as a memory address, and whether it names a real ID.
    assign in_ent_x = XW'(entity_id);
    assign in_idx   = in_ent_x[IW-1:0];
    assign ent_x    = XW'(ent_reg);
    assign ent_idx  = ent_x[IW-1:0];
    assign in_range = ({1'b0, ent_x} < EC_WIDE[XW:0]);
    assign stack_raddr = IW'(count_reg - CW'(1));
    assign pop_id_x = RW'(stack_rd_reg);

    // Memory write and read ports.
    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        if (meta_we)
        begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        stack_rd_reg <= stack_mem[stack_raddr];
        meta_rd_reg  <= meta_mem[in_idx];
    end

    // Latched request fields.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= action;
            ent_reg <= entity_id;
            par_reg <= parent_id;
        end
        rid_reg    <= rid_next;
        status_reg <= status_next;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            count_reg <= FULL_COUNT;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Sequencer: clearing pass, request execution and write-back.
    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        rid_next    = NO_ID;
        status_next = STAT_OK;
        stack_we    = 1'b0;
        stack_waddr = clr_reg;
        stack_wdata = clr_reg;
        meta_we     = 1'b0;
        meta_waddr  = clr_reg;
        meta_wdata  = {1'b0, NO_ID};
        case (state_reg)
            ST_CLEAR:
            begin
                stack_we = 1'b1;
                meta_we  = 1'b1;
                clr_next = clr_reg + IW'(1);
                if (clr_reg == LAST_ID)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
                case (act_reg)
                    ACT_SPAWN:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                            meta_we    = 1'b1;
                            meta_waddr = stack_rd_reg;
                            meta_wdata = {1'b1, NO_ID};
                            rid_next   = pop_id_x[RID_W-1:0];
                        end
                    end
                    ACT_DESPAWN:
                    begin
                        if (!in_range || !meta_rd_reg[MW-1])
                        begin
                            status_next = STAT_DEAD;
                        end
                        else
                        begin
                            meta_we    = 1'b1;
                            meta_waddr = ent_idx;
                            meta_wdata = {1'b0, NO_ID};
                            if (count_reg < FULL_COUNT)
                            begin
                                stack_we    = 1'b1;
                                stack_waddr = IW'(count_reg);
                                stack_wdata = ent_idx;
                                count_next  = count_reg + CW'(1);
                            end
                        end
                    end
                    ACT_SET_PAR:
                    begin
                        if (in_range)
                        begin
                            meta_we    = 1'b1;
                            meta_waddr = ent_idx;
                            meta_wdata = {meta_rd_reg[MW-1], par_reg};
                        end
                    end
                    default:
                    begin
                        if (in_range)
                        begin
                            rid_next = meta_rd_reg[PAR_W-1:0];
                        end
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign done      = done_reg;
    assign result_id = rid_reg;
    assign status    = status_reg;

endmodule
